FILE: hdl/eoa_pkg.sv
`default_nettype none
package eoa_pkg;

  // Channel count and internal state widths
  localparam int NUM_CHANNELS = 3;
  localparam int COUNT_BITS   = 32;
  localparam int DIST_BITS    = 48;

  // Fixed field and register widths
  localparam int GAIN_CH       = 3;
  localparam int GAIN_BITS     = 32;
  localparam int LIMIT_BITS    = 31;
  localparam int CH_BITS       = 2;
  localparam int RAW_BITS      = 32;
  localparam int TOTAL_BITS    = 32;
  localparam int DIST_OUT_BITS = 48;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Derived widths
  localparam int ADDR_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MAG_BITS  = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int PROD_BITS = COUNT_BITS + GAIN_BITS;
  localparam int SUM_BITS  = ((DIST_BITS > PROD_BITS) ? DIST_BITS : PROD_BITS) + 1;

  // Saturation bounds of the distance accumulator, at sum width
  localparam logic signed [SUM_BITS-1:0] SUM_DIST_MAX =
    SUM_BITS'({1'b0, {(DIST_BITS-1){1'b1}}});
  localparam logic signed [SUM_BITS-1:0] SUM_DIST_MIN = ~SUM_DIST_MAX;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_FWD_CH0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_REV_CH0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_FWD_CH1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_REV_CH1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_FWD_CH2 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_REV_CH2 = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_GLITCH_LIMIT = 3'd6;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [GAIN_CH-1:0][GAIN_BITS-1:0] gain_fwd;
    logic [GAIN_CH-1:0][GAIN_BITS-1:0] gain_rev;
    logic [LIMIT_BITS-1:0]             glitch_limit;
  } eoa_cfg_t;

  localparam eoa_cfg_t CFG_RST = '{
    gain_fwd:     {32'sd0, -32'sd21028, -32'sd20906},
    gain_rev:     {32'sd0, -32'sd21012, -32'sd20896},
    glitch_limit: 31'd2000
  };

  typedef struct packed {
    logic                       opcode;
    logic [CH_BITS-1:0]         channel;
    logic signed [RAW_BITS-1:0] raw_count;
  } eoa_item_t;

  // One channel's stored state
  typedef struct packed {
    logic [COUNT_BITS-1:0]       cur;
    logic [COUNT_BITS-1:0]       clr;
    logic [COUNT_BITS-1:0]       tot;
    logic signed [DIST_BITS-1:0] dist_acc;
  } eoa_state_t;

  typedef struct packed {
    logic                            en;
    logic [ADDR_W-1:0]               addr;
    eoa_state_t                      data;
  } eoa_wr_t;

  typedef struct packed {
    logic [CH_BITS-1:0]              out_channel;
    logic                            accepted;
    logic signed [TOTAL_BITS-1:0]    total_counts;
    logic signed [DIST_OUT_BITS-1:0] distance;
  } eoa_result_t;

  function automatic logic ch_in_range(input logic [CH_BITS-1:0] ch);
    return 32'(ch) < NUM_CHANNELS;
  endfunction

  // Channels without gain registers get zero gain
  function automatic logic signed [GAIN_BITS-1:0] gain_sel(input eoa_cfg_t cfg,
                                                           input logic [CH_BITS-1:0] ch,
                                                           input logic rev);
    logic signed [GAIN_BITS-1:0] g;
    g = '0;
    for (int i = 0; i < GAIN_CH; i++) begin
      if (32'(ch) == i) begin
        g = rev ? cfg.gain_rev[i] : cfg.gain_fwd[i];
      end
    end
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/eoa_if.sv
`default_nettype none
// Request channel
interface eoa_in_if;
  import eoa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [CH_BITS-1:0]         channel;
  logic signed [RAW_BITS-1:0] raw_count;
  modport source (output valid, opcode, channel, raw_count, input ready);
  modport sink   (input valid, opcode, channel, raw_count, output ready);
endinterface

// Result channel
interface eoa_out_if;
  import eoa_pkg::*;
  logic                            valid;
  logic                            ready;
  logic [CH_BITS-1:0]              out_channel;
  logic                            accepted;
  logic signed [TOTAL_BITS-1:0]    total_counts;
  logic signed [DIST_OUT_BITS-1:0] distance;
  modport source (output valid, out_channel, accepted, total_counts, distance, input ready);
  modport sink   (input valid, out_channel, accepted, total_counts, distance, output ready);
endinterface
`default_nettype wire

FILE: hdl/eoa_cfg_regs.sv
`default_nettype none
module eoa_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [eoa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [eoa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output eoa_pkg::eoa_cfg_t                       cfg
);
  import eoa_pkg::*;

  eoa_cfg_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_FWD_CH0: cfg_nxt.gain_fwd[0]  = cfg_wdata[GAIN_BITS-1:0];
        REG_GAIN_REV_CH0: cfg_nxt.gain_rev[0]  = cfg_wdata[GAIN_BITS-1:0];
        REG_GAIN_FWD_CH1: cfg_nxt.gain_fwd[1]  = cfg_wdata[GAIN_BITS-1:0];
        REG_GAIN_REV_CH1: cfg_nxt.gain_rev[1]  = cfg_wdata[GAIN_BITS-1:0];
        REG_GAIN_FWD_CH2: cfg_nxt.gain_fwd[2]  = cfg_wdata[GAIN_BITS-1:0];
        REG_GAIN_REV_CH2: cfg_nxt.gain_rev[2]  = cfg_wdata[GAIN_BITS-1:0];
        REG_GLITCH_LIMIT: cfg_nxt.glitch_limit = cfg_wdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hdl/eoa_state_ram.sv
`default_nettype none
module eoa_state_ram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [eoa_pkg::ADDR_W-1:0]  rd_addr,
  output eoa_pkg::eoa_state_t              rd_data,
  input  wire eoa_pkg::eoa_wr_t            wr
);
  import eoa_pkg::*;

  eoa_state_t              mem [NUM_CHANNELS];
  eoa_state_t              rd_q_r;
  logic [NUM_CHANNELS-1:0] vld_r;
  logic                    rd_vld_r;

  // Storage; a read at the written address returns the old entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Entry valid bits: an unwritten entry reads as zero state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

FILE: hdl/eoa_datapath.sv
`default_nettype none
module eoa_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        in_acc,
  input  wire eoa_pkg::eoa_item_t          in_item,
  input  wire eoa_pkg::eoa_cfg_t           cfg,
  output logic                             rd_en,
  output logic [eoa_pkg::ADDR_W-1:0]       rd_addr,
  input  wire eoa_pkg::eoa_state_t         rd_data,
  output eoa_pkg::eoa_wr_t                 wr,
  output logic                             res_valid,
  output eoa_pkg::eoa_result_t             res
);
  import eoa_pkg::*;

  // Stage 1: request plus state read
  logic       s1_valid_r;
  eoa_item_t  s1_item_r;

  // Stage 2: updated counts, base distance, product
  logic                        s2_valid_r;
  logic                        s2_inrng_r;
  logic                        s2_clear_r;
  logic                        s2_ok_r;
  logic [CH_BITS-1:0]          s2_ch_r;
  logic [ADDR_W-1:0]           s2_addr_r;
  eoa_state_t                  s2_st_r;
  logic signed [PROD_BITS-1:0] s2_prod_r;

  // Copy of the write made at the previous advance
  logic              lw_valid_r;
  logic [ADDR_W-1:0] lw_addr_r;
  eoa_state_t        lw_data_r;

  logic                        s1_inrng;
  logic [ADDR_W-1:0]           s1_addr;
  eoa_state_t                  s1_st;
  eoa_state_t                  s1_new;
  logic [COUNT_BITS-1:0]       s1_now;
  logic [COUNT_BITS-1:0]       s1_diff;
  logic [COUNT_BITS-1:0]       s1_mag_raw;
  logic [MAG_BITS-1:0]         s1_mag;
  logic                        s1_neg;
  logic                        s1_pass;
  logic                        s1_ok;
  logic signed [GAIN_BITS-1:0] s1_gain;
  logic signed [PROD_BITS-1:0] s1_prod;

  logic signed [DIST_BITS-1:0] s2_base;
  logic signed [SUM_BITS-1:0]  s2_sum;
  logic signed [DIST_BITS-1:0] s2_dist;
  eoa_state_t                  s2_wr_data;

  // Memory read issued with the request
  assign rd_en   = in_acc && ch_in_range(in_item.channel);
  assign rd_addr = ADDR_W'(in_item.channel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  // Stage 1: forward in-flight writes, step, glitch check, multiply
  always_comb begin
    s1_inrng = ch_in_range(s1_item_r.channel);
    s1_addr  = ADDR_W'(s1_item_r.channel);
    s1_st    = rd_data;
    // write that landed together with our read
    if (lw_valid_r && lw_addr_r == s1_addr) begin
      s1_st = lw_data_r;
    end
    // write happening now; its distance is picked up in stage 2
    if (s2_valid_r && s2_inrng_r && s2_addr_r == s1_addr) begin
      s1_st.cur = s2_st_r.cur;
      s1_st.clr = s2_st_r.clr;
      s1_st.tot = s2_st_r.tot;
    end
    s1_now     = s1_item_r.raw_count[COUNT_BITS-1:0];
    s1_diff    = s1_now - s1_st.cur;
    s1_neg     = s1_diff[COUNT_BITS-1];
    s1_mag_raw = s1_neg ? (COUNT_BITS'(0) - s1_diff) : s1_diff;
    s1_mag     = MAG_BITS'(s1_mag_raw);
    s1_pass    = s1_mag < MAG_BITS'(cfg.glitch_limit);
    s1_gain    = gain_sel(cfg, s1_item_r.channel, s1_neg);
    s1_prod    = $signed(s1_diff) * s1_gain;
    s1_new     = s1_st;
    s1_ok      = 1'b0;
    if (s1_item_r.opcode == OP_CLEAR) begin
      s1_new.clr = s1_st.cur;
      s1_new.tot = '0;
      s1_ok      = 1'b1;
    end else if (s1_pass) begin
      s1_new.cur = s1_now;
      s1_new.tot = s1_now - s1_st.clr;
      s1_ok      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inrng_r <= s1_inrng;
      s2_clear_r <= (s1_item_r.opcode == OP_CLEAR);
      s2_ok_r    <= s1_ok;
      s2_ch_r    <= s1_item_r.channel;
      s2_addr_r  <= s1_addr;
      s2_st_r    <= s1_new;
      s2_prod_r  <= s1_prod;
    end
  end

  // Stage 2: saturating distance update
  always_comb begin
    s2_base = (lw_valid_r && lw_addr_r == s2_addr_r) ? lw_data_r.dist_acc : s2_st_r.dist_acc;
    s2_sum  = SUM_BITS'(s2_base) + SUM_BITS'(s2_prod_r);
    if (s2_clear_r) begin
      s2_dist = '0;
    end else if (!s2_ok_r) begin
      s2_dist = s2_base;
    end else if (s2_sum > SUM_DIST_MAX) begin
      s2_dist = DIST_BITS'(SUM_DIST_MAX);
    end else if (s2_sum < SUM_DIST_MIN) begin
      s2_dist = DIST_BITS'(SUM_DIST_MIN);
    end else begin
      s2_dist = DIST_BITS'(s2_sum);
    end
    s2_wr_data          = s2_st_r;
    s2_wr_data.dist_acc = s2_dist;
  end

  // Write-back
  assign wr.en   = adv && s2_valid_r && s2_inrng_r;
  assign wr.addr = s2_addr_r;
  assign wr.data = s2_wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (adv) begin
      lw_valid_r <= s2_valid_r && s2_inrng_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lw_addr_r <= s2_addr_r;
      lw_data_r <= s2_wr_data;
    end
  end

  // Result; out-of-range channels report zeros
  assign res_valid        = s2_valid_r;
  assign res.out_channel  = s2_ch_r;
  assign res.accepted     = s2_inrng_r && s2_ok_r;
  assign res.total_counts = s2_inrng_r ? TOTAL_BITS'($signed(s2_st_r.tot)) : '0;
  assign res.distance     = s2_inrng_r ? DIST_OUT_BITS'(s2_dist) : '0;

endmodule
`default_nettype wire

FILE: hdl/encoder_odometry_accumulator_core.sv
// Wheel encoder odometry for three channels. Each request (sample or clear)
// returns one result with the channel's total counts since its last clear,
// its Q32.16 distance and an accepted flag. One request per clock is taken
// when the result side keeps up. A taken request is loaded into stage 1,
// which reads the channel state RAM, then into stage 2, which applies the
// saturating add, and then into the output register. Throughput is set by
// the single-port-per-direction state RAM: one read and one write per
// cycle, with the two writes still in flight forwarded into later requests
// to the same channel. State entries read as zero after reset through
// per-entry valid bits, so no clearing pass is needed. Configuration writes
// take effect on the next cycle and should only be made while no request is
// in flight.
`default_nettype none
module encoder_odometry_accumulator_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  eoa_in_if.sink                                  in_ch,
  eoa_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [eoa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [eoa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import eoa_pkg::*;

  logic        adv;
  logic        in_acc;
  eoa_item_t   in_item;
  eoa_cfg_t    cfg;
  logic        rd_en;
  logic [ADDR_W-1:0] rd_addr;
  eoa_state_t  rd_data;
  eoa_wr_t     wr;
  logic        res_valid;
  eoa_result_t res;
  logic        out_valid_r;
  eoa_result_t out_res_r;

  // Pipeline moves whenever the output register is free or being drained
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;

  assign in_item.opcode    = in_ch.opcode;
  assign in_item.channel   = in_ch.channel;
  assign in_item.raw_count = in_ch.raw_count;

  eoa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  eoa_state_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  eoa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_acc    (in_acc),
    .in_item   (in_item),
    .cfg       (cfg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_channel  = out_res_r.out_channel;
  assign out_ch.accepted     = out_res_r.accepted;
  assign out_ch.total_counts = out_res_r.total_counts;
  assign out_ch.distance     = out_res_r.distance;

  // A stalled result holds off new requests
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while result stalled");

  // Out-of-range channels never report state
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ch_in_range(out_res_r.out_channel)) |->
    (!out_res_r.accepted && out_res_r.total_counts == '0 && out_res_r.distance == '0))
    else $error("out-of-range channel reported state");

  // Request reaches the output once stage 2 and the output register advance unstalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc ##1 adv ##1 adv) |=> out_valid_r)
    else $error("result lost in pipeline");

endmodule
`default_nettype wire
